### rtl/itocr_pkg.sv
// Package: shared constants, curve tables, root table and divider handshake types.
package itocr_pkg;

  // Phases that time; the transaction always carries three
  localparam int PHASES    = 3;
  localparam int NUM_CH    = 3;
  localparam int TIME_BITS = 32;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_DIAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICKUP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STANDARD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE     = 3'd4;

  localparam logic [15:0] TIME_DIAL_RST = 16'd256;
  localparam logic [15:0] PICKUP_RST    = 16'd1000;
  localparam logic [19:0] TICK_RST      = 20'd1000;
  localparam logic [2:0]  CURVE_RST     = 3'd1;

  // Fixed-point widths
  localparam logic [31:0] ONE30 = 32'h4000_0000;
  localparam int LOG_W  = 35;
  localparam int NUM_W  = 56;
  localparam int DEN_W  = 64;
  localparam int V_W    = 57;
  localparam int W_W    = 30;
  localparam int Y_W    = 88;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam logic [31:0] US_SCALE = 32'd15625;
  localparam int Q16_SHIFT = 18;

  // Exponent kinds
  localparam logic [1:0] PK_SQUARE = 2'd0;
  localparam logic [1:0] PK_ONE    = 2'd1;
  localparam logic [1:0] PK_P02    = 2'd2;
  localparam logic [1:0] PK_P04    = 2'd3;
  localparam logic [26:0] K_P02 = 27'd42949673;
  localparam logic [26:0] K_P04 = 27'd85899346;

  typedef logic [31:0] root_tab_t [0:29];

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // Integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Roots 2^(2^-i), i = 1..30, in Q.30
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 0; i < 30; i++) begin
      r      = isqrt64(r << 30);
      tab[i] = r[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

  function automatic logic curve_known(input logic [2:0] sel);
    return (sel >= 3'd1) && (sel <= 3'd5);
  endfunction

  function automatic logic [22:0] c16_of(input logic std, input logic [2:0] sel);
    logic [22:0] c;
    case ({std, sel})
      4'b0001: c = 23'd3375;
      4'b0010: c = 23'd1285161;
      4'b0011: c = 23'd1848115;
      4'b0100: c = 23'd389939;
      4'b0101: c = 23'd1569;
      4'b1001: c = 23'd9175;
      4'b1010: c = 23'd884736;
      4'b1011: c = 23'd5242880;
      4'b1100: c = 23'd7864320;
      4'b1101: c = 23'd3277;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [14:0] b16_of(input logic std, input logic [2:0] sel);
    logic [14:0] b;
    case ({std, sel})
      4'b0001: b = 15'd7471;
      4'b0010: b = 15'd32178;
      4'b0011: b = 15'd7976;
      4'b0100: b = 15'd11796;
      4'b0101: b = 15'd1110;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] pk_of(input logic std, input logic [2:0] sel);
    logic [1:0] k;
    case ({std, sel})
      4'b0001: k = PK_P02;
      4'b0101: k = PK_P02;
      4'b1001: k = PK_P02;
      4'b1010: k = PK_ONE;
      4'b1100: k = PK_ONE;
      4'b1101: k = PK_P04;
      default: k = PK_SQUARE;
    endcase
    return k;
  endfunction

endpackage

### rtl/itocr_ifs.sv
// Interfaces: sample input, result output and configuration write channels.
interface itocr_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] phase_a_real;
  logic signed [15:0] phase_a_imag;
  logic signed [15:0] phase_b_real;
  logic signed [15:0] phase_b_imag;
  logic signed [15:0] phase_c_real;
  logic signed [15:0] phase_c_imag;
  modport source (output valid, kind, phase_a_real, phase_a_imag, phase_b_real,
                  phase_b_imag, phase_c_real, phase_c_imag, input ready);
  modport sink (input valid, kind, phase_a_real, phase_a_imag, phase_b_real,
                phase_b_imag, phase_c_real, phase_c_imag, output ready);
endinterface

interface itocr_out_if;
  logic valid;
  logic ready;
  logic trip_a;
  logic trip_b;
  logic trip_c;
  logic pickup_a;
  logic pickup_b;
  logic pickup_c;
  modport source (output valid, trip_a, trip_b, trip_c, pickup_a, pickup_b, pickup_c,
                  input ready);
  modport sink (input valid, trip_a, trip_b, trip_c, pickup_a, pickup_b, pickup_c,
                output ready);
endinterface

interface itocr_cfg_if;
  import itocr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/itocr_div.sv
// Restoring divider: one quotient bit per cycle.
module itocr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  itocr_pkg::div_req_t req,
  output itocr_pkg::div_rsp_t rsp
);
  import itocr_pkg::*;

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W:0]       trial;
  logic                 ge;

  // Shift in the next numerator bit and try the subtract
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      den_nxt = req.den;
      quo_nxt = req.num;
    end else if (run_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### rtl/inverse_time_overcurrent_relay.sv
// Top level: three-phase inverse-time overcurrent relay with a shared multiplier sequencer.
// One transaction at a time. A trip reset clears tripped phases and their timers; a sample
//   tick runs each phase through its magnitude and pickup check, and a timing phase adds a
//   56-bit divide on a square-law curve, or log2, exp2 and a divide on a power-law curve; a
//   power-law curve also takes the pickup log2 once per tick. Log2 squarings and exp2 root
//   products use the one 32x32 multiplier. A stalled result holds the block until taken.
// Reset (rst_n low, synchronous): configuration to defaults, timers, trip and pickup clear.
module inverse_time_overcurrent_relay (
  input  logic         clk,
  input  logic         rst_n,
  itocr_in_if.sink     in_ch,
  itocr_out_if.source  out_ch,
  itocr_cfg_if.sink    cfg_ch
);
  import itocr_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RST   = 5'd1;
  localparam logic [4:0] S_PSQ   = 5'd2;
  localparam logic [4:0] S_WMUL  = 5'd3;
  localparam logic [4:0] S_SQRE  = 5'd4;
  localparam logic [4:0] S_SQIM  = 5'd5;
  localparam logic [4:0] S_PCHK  = 5'd6;
  localparam logic [4:0] S_LNORM = 5'd7;
  localparam logic [4:0] S_LSQ   = 5'd8;
  localparam logic [4:0] S_LEND  = 5'd9;
  localparam logic [4:0] S_EMUL  = 5'd10;
  localparam logic [4:0] S_EXP   = 5'd11;
  localparam logic [4:0] S_EXPF  = 5'd12;
  localparam logic [4:0] S_RMUL  = 5'd13;
  localparam logic [4:0] S_DIVGO = 5'd14;
  localparam logic [4:0] S_DIVW  = 5'd15;
  localparam logic [4:0] S_TM0   = 5'd16;
  localparam logic [4:0] S_TM1   = 5'd17;
  localparam logic [4:0] S_TM2   = 5'd18;
  localparam logic [4:0] S_TRIP  = 5'd19;
  localparam logic [4:0] S_NEXT  = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  // Configuration registers
  logic [15:0] dial_r, dial_nxt;
  logic [15:0] pickup_r, pickup_nxt;
  logic [19:0] tick_r, tick_nxt;
  logic        std_r, std_nxt;
  logic [2:0]  sel_r, sel_nxt;

  // Control and phase state
  logic [4:0]           state_r, state_nxt;
  logic [1:0]           ph_r, ph_nxt;
  logic [NUM_CH-1:0]    trip_r, trip_nxt;
  logic [NUM_CH-1:0]    pick_r, pick_nxt;
  logic [TIME_BITS-1:0] elapsed_r [0:NUM_CH-1];
  logic [TIME_BITS-1:0] elapsed_nxt [0:NUM_CH-1];
  logic                 out_valid_r, out_valid_nxt;
  logic [NUM_CH-1:0]    out_trip_r, out_trip_nxt;
  logic [NUM_CH-1:0]    out_pick_r, out_pick_nxt;

  // Datapath registers
  logic [15:0]      cur_re_r [0:NUM_CH-1];
  logic [15:0]      cur_re_nxt [0:NUM_CH-1];
  logic [15:0]      cur_im_r [0:NUM_CH-1];
  logic [15:0]      cur_im_nxt [0:NUM_CH-1];
  logic [31:0]      p2_r, p2_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic [31:0]      s_r, s_nxt;
  logic [31:0]      lx_r, lx_nxt;
  logic [4:0]       ln_r, ln_nxt;
  logic [30:0]      lm_r, lm_nxt;
  logic [29:0]      fr_r, fr_nxt;
  logic             lsel_r, lsel_nxt;
  logic [LOG_W-1:0] lp_r, lp_nxt;
  logic [LOG_W-1:0] e_r, e_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             tsat_r, tsat_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [V_W-1:0]   v_r, v_nxt;
  logic [63:0]      pl_r, pl_nxt;
  logic [63:0]      phh_r, phh_nxt;
  logic [Y_W-1:0]   y_r, y_nxt;

  // Shared multiplier and helpers
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_p;
  logic [15:0]            pk, re_u, im_u, re_mag, im_mag;
  logic [22:0]            c16;
  logic [14:0]            b16;
  logic [1:0]             pkind;
  logic                   known;
  logic [26:0]            kconst;
  logic [LOG_W-1:0]       logv, lsub;
  logic [29:0]            ehi;
  logic [29:0]            efr;
  logic [63:0]            dx;
  logic [TIME_BITS-1:0]   e_cur;
  logic [TIME_BITS:0]     e_sum, e_one;
  logic [TIME_BITS-1:0]   e_adv;
  logic [TIME_BITS+3:0]   rdiv;
  logic [Y_W-1:0]         r_cmp;
  logic                   hit, in_acc;
  logic [31:0]            norm_x;
  logic [4:0]             norm_n;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  itocr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Curve lookup from configuration
  assign pk     = (pickup_r == 16'd0) ? 16'd1 : pickup_r;
  assign c16    = c16_of(std_r, sel_r);
  assign b16    = b16_of(std_r, sel_r);
  assign pkind  = pk_of(std_r, sel_r);
  assign known  = curve_known(sel_r);
  assign kconst = (pkind == PK_P04) ? K_P04 : K_P02;

  // Magnitudes of the current phase components
  assign re_u   = cur_re_r[ph_r];
  assign im_u   = cur_im_r[ph_r];
  assign re_mag = re_u[15] ? (~re_u + 16'd1) : re_u;
  assign im_mag = im_u[15] ? (~im_u + 16'd1) : im_u;

  // Select multiplier operands by sequencer step
  always_comb begin
    case (state_r)
      S_PSQ: begin
        mul_a = {16'd0, pk};
        mul_b = {16'd0, pk};
      end
      S_WMUL: begin
        mul_a = {16'd0, dial_r};
        mul_b = US_SCALE;
      end
      S_SQRE: begin
        mul_a = {16'd0, re_mag};
        mul_b = {16'd0, re_mag};
      end
      S_SQIM: begin
        mul_a = {16'd0, im_mag};
        mul_b = {16'd0, im_mag};
      end
      S_LSQ: begin
        mul_a = {1'b0, lm_r};
        mul_b = {1'b0, lm_r};
      end
      S_EMUL: begin
        mul_a = e_r[31:0];
        mul_b = {5'd0, kconst};
      end
      S_EXP: begin
        mul_a = acc_r;
        mul_b = ROOT_TAB[cnt_r];
      end
      S_RMUL: begin
        mul_a = {9'd0, c16};
        mul_b = p2_r;
      end
      S_TM0: begin
        mul_a = v_r[31:0];
        mul_b = {2'd0, w_r};
      end
      S_TM1: begin
        mul_a = {7'd0, v_r[V_W-1:32]};
        mul_b = {2'd0, w_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Log, exponent and timing helpers
  assign logv  = {ln_r, fr_r};
  assign lsub  = (logv > lp_r) ? (logv - lp_r) : '0;
  assign ehi   = {27'd0, e_r[LOG_W-1:32]} * {3'd0, kconst};
  assign efr   = e_r[29:0];
  assign dx    = ({32'd0, acc_r} << e_r[LOG_W-1:30]) - {32'd0, ONE30};
  assign e_cur = elapsed_r[ph_r];
  assign e_sum = {1'b0, e_cur} + (TIME_BITS+1)'(tick_r);
  assign e_adv = e_sum[TIME_BITS] ? TMAX : e_sum[TIME_BITS-1:0];
  assign e_one = {1'b0, e_cur} + (TIME_BITS+1)'(1);
  assign rdiv  = std_r ? (TIME_BITS+4)'(e_one)
                       : ((TIME_BITS+4)'(e_one) << 3) - (TIME_BITS+4)'(e_one);
  assign r_cmp = Y_W'(rdiv) << Q16_SHIFT;
  assign hit   = (e_cur == TMAX) || (!tsat_r && (y_r < r_cmp));

  // Normalize step: skip leading zero groups of 16, 8, 4, 2, 1
  always_comb begin
    norm_x = lx_r;
    norm_n = ln_r;
    case (cnt_r)
      5'd0: if (lx_r[31:16] == '0) begin
        norm_x = lx_r << 16;
        norm_n = ln_r - 5'd16;
      end
      5'd1: if (lx_r[31:24] == '0) begin
        norm_x = lx_r << 8;
        norm_n = ln_r - 5'd8;
      end
      5'd2: if (lx_r[31:28] == '0) begin
        norm_x = lx_r << 4;
        norm_n = ln_r - 5'd4;
      end
      5'd3: if (lx_r[31:30] == '0) begin
        norm_x = lx_r << 2;
        norm_n = ln_r - 5'd2;
      end
      5'd4: if (!lx_r[31]) begin
        norm_x = lx_r << 1;
        norm_n = ln_r - 5'd1;
      end
      default: begin
        norm_x = lx_r;
        norm_n = ln_r;
      end
    endcase
  end

  assign in_acc         = in_ch.valid && in_ch.ready;
  assign div_req.start  = (state_r == S_DIVGO);
  assign div_req.num    = num_r;
  assign div_req.den    = den_r;

  // Sequencer
  always_comb begin
    dial_nxt      = dial_r;
    pickup_nxt    = pickup_r;
    tick_nxt      = tick_r;
    std_nxt       = std_r;
    sel_nxt       = sel_r;
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    trip_nxt      = trip_r;
    pick_nxt      = pick_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_trip_nxt  = out_trip_r;
    out_pick_nxt  = out_pick_r;
    cur_re_nxt    = cur_re_r;
    cur_im_nxt    = cur_im_r;
    p2_nxt        = p2_r;
    w_nxt         = w_r;
    s_nxt         = s_r;
    lx_nxt        = lx_r;
    ln_nxt        = ln_r;
    lm_nxt        = lm_r;
    fr_nxt        = fr_r;
    lsel_nxt      = lsel_r;
    lp_nxt        = lp_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    tsat_nxt      = tsat_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    v_nxt         = v_r;
    pl_nxt        = pl_r;
    phh_nxt       = phh_r;
    y_nxt         = y_r;

    // Apply configuration writes
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TIME_DIAL: dial_nxt   = cfg_ch.data[15:0];
        REG_PICKUP:    pickup_nxt = cfg_ch.data[15:0];
        REG_TICK:      tick_nxt   = cfg_ch.data;
        REG_STANDARD:  std_nxt    = cfg_ch.data[0];
        REG_CURVE:     sel_nxt    = cfg_ch.data[2:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_re_nxt[0] = in_ch.phase_a_real;
          cur_im_nxt[0] = in_ch.phase_a_imag;
          cur_re_nxt[1] = in_ch.phase_b_real;
          cur_im_nxt[1] = in_ch.phase_b_imag;
          cur_re_nxt[2] = in_ch.phase_c_real;
          cur_im_nxt[2] = in_ch.phase_c_imag;
          ph_nxt        = '0;
          state_nxt     = in_ch.kind ? S_RST : S_PSQ;
        end
      end
      S_RST: begin
        // Clear tripped phases and their timers
        for (int i = 0; i < PHASES; i++) begin
          if (trip_r[i]) begin
            trip_nxt[i]    = 1'b0;
            elapsed_nxt[i] = '0;
          end
        end
        state_nxt = S_DONE;
      end
      S_PSQ: begin
        p2_nxt    = mul_p[31:0];
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        w_nxt = mul_p[W_W-1:0];
        if (known && (pkind != PK_SQUARE)) begin
          lx_nxt    = p2_r;
          ln_nxt    = 5'd31;
          lsel_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_LNORM;
        end else begin
          state_nxt = S_SQRE;
        end
      end
      S_SQRE: begin
        s_nxt     = mul_p[31:0];
        state_nxt = S_SQIM;
      end
      S_SQIM: begin
        s_nxt     = s_r + mul_p[31:0];
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        pick_nxt[ph_r] = s_r > p2_r;
        state_nxt      = S_NEXT;
        if (s_r <= p2_r) begin
          elapsed_nxt[ph_r] = '0;
        end else if (!trip_r[ph_r]) begin
          if (!known) begin
            elapsed_nxt[ph_r] = e_adv;
          end else if (pkind == PK_SQUARE) begin
            state_nxt = S_RMUL;
          end else begin
            lx_nxt    = s_r;
            ln_nxt    = 5'd31;
            lsel_nxt  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_LNORM;
          end
        end
      end
      S_LNORM: begin
        lx_nxt  = norm_x;
        ln_nxt  = norm_n;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd4) begin
          lm_nxt    = norm_x[31:1];
          fr_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_LSQ;
        end
      end
      S_LSQ: begin
        // Square the mantissa and take one fraction bit
        fr_nxt  = {fr_r[28:0], mul_p[61]};
        lm_nxt  = mul_p[61] ? mul_p[61:31] : mul_p[60:30];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          state_nxt = S_LEND;
        end
      end
      S_LEND: begin
        if (!lsel_r) begin
          lp_nxt    = logv;
          state_nxt = S_SQRE;
        end else if (pkind == PK_ONE) begin
          e_nxt     = lsub >> 1;
          acc_nxt   = ONE30;
          cnt_nxt   = '0;
          state_nxt = S_EXP;
        end else begin
          e_nxt     = lsub;
          state_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        e_nxt     = LOG_W'(mul_p[63:32]) + LOG_W'(ehi);
        acc_nxt   = ONE30;
        cnt_nxt   = '0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        // Multiply in the root for each set fraction bit
        if (efr[5'd29 - cnt_r]) begin
          acc_nxt = mul_p[61:30];
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          state_nxt = S_EXPF;
        end
      end
      S_EXPF: begin
        if (dx == '0) begin
          tsat_nxt  = 1'b1;
          state_nxt = S_TRIP;
        end else begin
          tsat_nxt  = 1'b0;
          num_nxt   = {3'd0, c16, 30'd0};
          den_nxt   = dx;
          state_nxt = S_DIVGO;
        end
      end
      S_RMUL: begin
        tsat_nxt  = 1'b0;
        num_nxt   = mul_p[NUM_W-1:0];
        den_nxt   = {32'd0, s_r - p2_r};
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          v_nxt     = {1'b0, div_rsp.quo} + V_W'(b16);
          state_nxt = S_TM0;
        end
      end
      S_TM0: begin
        pl_nxt    = mul_p;
        state_nxt = S_TM1;
      end
      S_TM1: begin
        phh_nxt   = mul_p;
        state_nxt = S_TM2;
      end
      S_TM2: begin
        y_nxt     = {phh_r[55:0], 32'd0} + Y_W'(pl_r);
        state_nxt = S_TRIP;
      end
      S_TRIP: begin
        // Latch the trip, or advance the timer
        if (hit) begin
          trip_nxt[ph_r] = 1'b1;
        end else begin
          elapsed_nxt[ph_r] = e_adv;
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (ph_r == 2'(PHASES - 1)) begin
          state_nxt = S_DONE;
        end else begin
          ph_nxt    = ph_r + 2'd1;
          state_nxt = S_SQRE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_trip_nxt  = trip_r;
          out_pick_nxt  = pick_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dial_r      <= TIME_DIAL_RST;
      pickup_r    <= PICKUP_RST;
      tick_r      <= TICK_RST;
      std_r       <= 1'b0;
      sel_r       <= CURVE_RST;
      state_r     <= S_IDLE;
      ph_r        <= '0;
      trip_r      <= '0;
      pick_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        elapsed_r[i] <= '0;
      end
    end else begin
      dial_r      <= dial_nxt;
      pickup_r    <= pickup_nxt;
      tick_r      <= tick_nxt;
      std_r       <= std_nxt;
      sel_r       <= sel_nxt;
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      trip_r      <= trip_nxt;
      pick_r      <= pick_nxt;
      out_valid_r <= out_valid_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_trip_r <= out_trip_nxt;
    out_pick_r <= out_pick_nxt;
    cur_re_r   <= cur_re_nxt;
    cur_im_r   <= cur_im_nxt;
    p2_r       <= p2_nxt;
    w_r        <= w_nxt;
    s_r        <= s_nxt;
    lx_r       <= lx_nxt;
    ln_r       <= ln_nxt;
    lm_r       <= lm_nxt;
    fr_r       <= fr_nxt;
    lsel_r     <= lsel_nxt;
    lp_r       <= lp_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    tsat_r     <= tsat_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    v_r        <= v_nxt;
    pl_r       <= pl_nxt;
    phh_r      <= phh_nxt;
    y_r        <= y_nxt;
  end

  // Drive the channels
  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.trip_a   = out_trip_r[0];
  assign out_ch.trip_b   = out_trip_r[1];
  assign out_ch.trip_c   = out_trip_r[2];
  assign out_ch.pickup_a = out_pick_r[0];
  assign out_ch.pickup_b = out_pick_r[1];
  assign out_ch.pickup_c = out_pick_r[2];

endmodule

### rtl/itocr_checker.sv
// Checker: port-level assertions on the relay, attached by bind.
module itocr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_flags
);

  // Drop ready for the cycle after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after a transaction");

  // A new result appears only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while the block was busy");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flags))
    else $error("stalled result changed or dropped");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind inverse_time_overcurrent_relay itocr_checker u_itocr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_flags ({out_ch.trip_a, out_ch.trip_b, out_ch.trip_c,
               out_ch.pickup_a, out_ch.pickup_b, out_ch.pickup_c})
);
